FILE: rtl/srp_pkg.sv
// srp_pkg: shared types and constants for the shelf rectangle packer.
// Holds operation codes, configuration register indexes, reset values and the result type.
// No dependencies.
package srp_pkg;

    // Field widths fixed by the interface
    localparam int DIM_BITS   = 16;
    localparam int SPACE_BITS = 12;
    localparam int OP_BITS    = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int COUNT_BITS = 16;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_ADD       = 3'd0;
    localparam logic [OP_BITS-1:0] OP_CHECK     = 3'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR     = 3'd2;
    localparam logic [OP_BITS-1:0] OP_SET_HORIZ = 3'd3;
    localparam logic [OP_BITS-1:0] OP_SET_VERT  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_BOUND_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOUND_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_INIT_H_SPACE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_INIT_V_SPACE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_INIT_LINE_H  = 3'd4;

    // Configuration reset values
    localparam logic [DIM_BITS-1:0]   RST_BOUND_WIDTH  = 16'd1024;
    localparam logic [DIM_BITS-1:0]   RST_BOUND_HEIGHT = 16'd1024;
    localparam logic [SPACE_BITS-1:0] RST_INIT_H_SPACE = 12'd1;
    localparam logic [SPACE_BITS-1:0] RST_INIT_V_SPACE = 12'd1;
    localparam logic [DIM_BITS-1:0]   RST_INIT_LINE_H  = 16'd32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;

    // One result transfer
    typedef struct packed {
        logic                fits;
        logic [DIM_BITS-1:0] pos_x;
        logic [DIM_BITS-1:0] pos_y;
        logic                is_empty;
    } t_result;

endpackage

FILE: rtl/shelf_rect_packer_top.sv
// shelf_rect_packer_top: row (shelf) packer for atlas rectangles; depends on srp_pkg.
// Each result is registered in the output register, or in the skid entry behind it while
// the output register still holds an untaken result. Throughput: one item per cycle while
//   o_in_stall is low; the skid entry lets the next item enter while a result waits.
// Reset (synchronous, active low): cursors and count cleared, configuration registers
//   to their defaults, spacings and line height loaded from them, output stage emptied.
module shelf_rect_packer_top #(
    parameter int COORD_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [srp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [srp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [srp_pkg::OP_BITS-1:0]       i_operation,
    input  logic [srp_pkg::DIM_BITS-1:0]      i_rect_width,
    input  logic [srp_pkg::DIM_BITS-1:0]      i_rect_height,
    input  logic [srp_pkg::SPACE_BITS-1:0]    i_new_h_spacing,
    input  logic [srp_pkg::SPACE_BITS-1:0]    i_new_v_spacing,
    input  logic [srp_pkg::DIM_BITS-1:0]      i_new_line_height,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_fits,
    output logic [srp_pkg::DIM_BITS-1:0]      o_pos_x,
    output logic [srp_pkg::DIM_BITS-1:0]      o_pos_y,
    output logic                              o_is_empty
);

    localparam int CW = COORD_BITS;
    // internal sum width: covers cursor plus two spacings, line height and rectangle
    localparam int SW = ((CW > 17) ? CW : 17) + 3;
    localparam logic [SW-1:0] CMAX = (SW'(1) << CW) - SW'(1);

    localparam int DW = srp_pkg::DIM_BITS;
    localparam int PW = srp_pkg::SPACE_BITS;

    // configuration registers
    logic [DW-1:0] r_bound_w, r_bound_h, r_init_lh;
    logic [PW-1:0] r_init_hs, r_init_vs;

    // packer state
    logic [CW-1:0] r_cur_x, r_cur_y;
    logic [srp_pkg::COUNT_BITS-1:0] r_count;
    logic [PW-1:0] r_h_sp, r_v_sp;
    logic [DW-1:0] r_line_h;

    logic [CW-1:0] n_cur_x, n_cur_y;
    logic [srp_pkg::COUNT_BITS-1:0] n_count;
    logic [PW-1:0] n_h_sp, n_v_sp;
    logic [DW-1:0] n_line_h;

    // output stage
    logic             r_out_valid, r_skid_valid;
    srp_pkg::t_result r_out, r_skid, n_res;

    logic in_xfer, out_xfer, cfg_hit;

    function automatic logic [SW-1:0] f_sat(input logic [SW-1:0] v);
        f_sat = (v > CMAX) ? CMAX : v;
    endfunction

    assign o_in_stall = r_skid_valid;
    assign in_xfer    = i_in_valid && !r_skid_valid;
    assign out_xfer   = r_out_valid && !i_out_stall;
    assign cfg_hit    = i_cfg_we && (i_cfg_index <= srp_pkg::REG_INIT_LINE_H);

    // fit test
    logic [SW-1:0] cx_w, cy_w, bw_w, bh_w, hs_w, vs_w, lh_w, rw_w, rh_w;
    logic [SW-1:0] tot_w, tot_h, left, row_down;
    logic          too_big, row_ok, next_ok, fit;

    assign cx_w = SW'(r_cur_x);
    assign cy_w = SW'(r_cur_y);
    assign bw_w = SW'(r_bound_w);
    assign bh_w = SW'(r_bound_h);
    assign hs_w = SW'(r_h_sp);
    assign vs_w = SW'(r_v_sp);
    assign lh_w = SW'(r_line_h);
    assign rw_w = SW'(i_rect_width);
    assign rh_w = SW'(i_rect_height);

    assign tot_w    = (hs_w << 1) + rw_w;
    assign tot_h    = (vs_w << 1) + rh_w;
    assign too_big  = (tot_w > bw_w) || (i_rect_height > r_line_h);
    assign left     = (cx_w > bw_w) ? '0 : (bw_w - cx_w);
    assign row_ok   = (left >= tot_w);
    assign row_down = cy_w + vs_w + lh_w;
    assign next_ok  = ((row_down + tot_h) <= bh_w);
    assign fit      = !too_big && (row_ok || next_ok);

    // placement arithmetic
    logic [SW-1:0] cy_eff, cx_eff, pos_x_s, pos_y_s, cx_adv;
    assign cy_eff  = row_ok ? cy_w : f_sat(row_down);
    assign cx_eff  = row_ok ? cx_w : '0;
    assign pos_x_s = f_sat(cx_eff + hs_w);
    assign pos_y_s = f_sat(cy_eff + vs_w);
    assign cx_adv  = f_sat(cx_eff + hs_w + rw_w);

    // set horizontal: shift cursor right by the shrink, clamped
    logic [SW-1:0] hx_sum, hx_clamp, hx_new;
    assign hx_sum   = cx_w + (hs_w - SW'(i_new_h_spacing));
    assign hx_clamp = (hx_sum < bw_w) ? hx_sum : bw_w;
    assign hx_new   = f_sat(hx_clamp);

    // set vertical: move cursor down by the larger spacing, clamped
    logic [SW-1:0] vmax, vy_sum, vy_clamp, vy_new;
    assign vmax     = (r_v_sp > i_new_v_spacing) ? vs_w : SW'(i_new_v_spacing);
    assign vy_sum   = cy_w + vmax;
    assign vy_clamp = (vy_sum < bh_w) ? vy_sum : bh_w;
    assign vy_new   = f_sat(vy_clamp);

    // next state and result
    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_count  = r_count;
        n_h_sp   = r_h_sp;
        n_v_sp   = r_v_sp;
        n_line_h = r_line_h;
        n_res.fits  = 1'b1;
        n_res.pos_x = '0;
        n_res.pos_y = '0;
        unique case (i_operation)
            srp_pkg::OP_ADD: begin
                if (fit) begin
                    n_cur_y     = cy_eff[CW-1:0];
                    n_cur_x     = cx_adv[CW-1:0];
                    n_res.pos_x = pos_x_s[DW-1:0];
                    n_res.pos_y = pos_y_s[DW-1:0];
                    if (r_count != srp_pkg::COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    n_res.fits = 1'b0;
                end
            end
            srp_pkg::OP_CHECK: begin
                n_res.fits = fit;
            end
            srp_pkg::OP_CLEAR: begin
                n_cur_x = '0;
                n_cur_y = '0;
                n_count = '0;
            end
            srp_pkg::OP_SET_HORIZ: begin
                if (i_new_h_spacing < r_h_sp) begin
                    n_cur_x = hx_new[CW-1:0];
                end
                n_h_sp = i_new_h_spacing;
            end
            srp_pkg::OP_SET_VERT: begin
                n_cur_y  = vy_new[CW-1:0];
                n_cur_x  = '0;
                n_v_sp   = i_new_v_spacing;
                n_line_h = i_new_line_height;
            end
            default: begin
                // unused codes leave the state alone
            end
        endcase
        n_res.is_empty = (n_count == '0);
    end

    // configuration registers, spacing reload and packer state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_w <= srp_pkg::RST_BOUND_WIDTH;
            r_bound_h <= srp_pkg::RST_BOUND_HEIGHT;
            r_init_hs <= srp_pkg::RST_INIT_H_SPACE;
            r_init_vs <= srp_pkg::RST_INIT_V_SPACE;
            r_init_lh <= srp_pkg::RST_INIT_LINE_H;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_count   <= '0;
            r_h_sp    <= srp_pkg::RST_INIT_H_SPACE;
            r_v_sp    <= srp_pkg::RST_INIT_V_SPACE;
            r_line_h  <= srp_pkg::RST_INIT_LINE_H;
        end else if (cfg_hit) begin
            // write the register, then reload spacings from the (new) initial values
            r_h_sp   <= r_init_hs;
            r_v_sp   <= r_init_vs;
            r_line_h <= r_init_lh;
            unique case (i_cfg_index)
                srp_pkg::REG_BOUND_WIDTH:  r_bound_w <= i_cfg_data;
                srp_pkg::REG_BOUND_HEIGHT: r_bound_h <= i_cfg_data;
                srp_pkg::REG_INIT_H_SPACE: begin
                    r_init_hs <= i_cfg_data[PW-1:0];
                    r_h_sp    <= i_cfg_data[PW-1:0];
                end
                srp_pkg::REG_INIT_V_SPACE: begin
                    r_init_vs <= i_cfg_data[PW-1:0];
                    r_v_sp    <= i_cfg_data[PW-1:0];
                end
                default: begin
                    r_init_lh <= i_cfg_data;
                    r_line_h  <= i_cfg_data;
                end
            endcase
        end else if (in_xfer) begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_count  <= n_count;
            r_h_sp   <= n_h_sp;
            r_v_sp   <= n_v_sp;
            r_line_h <= n_line_h;
        end
    end

    // output stage: result register with a skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_xfer) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_xfer;
            end
        end else if (in_xfer) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // payload of the output stage
    always_ff @(posedge i_clk) begin
        if (out_xfer) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (in_xfer) begin
            if (r_out_valid) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_fits      = r_out.fits;
    assign o_pos_x     = r_out.pos_x;
    assign o_pos_y     = r_out.pos_y;
    assign o_is_empty  = r_out.is_empty;

    // checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result in front");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result dropped");

    a_reject_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.fits) |-> (r_out.pos_x == '0 && r_out.pos_y == '0))
        else $error("rejected rectangle carries a position");

    a_empty_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_empty) |-> (r_out.pos_x == '0 && r_out.pos_y == '0))
        else $error("empty packer reported a placement");

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: self-checking bench for shelf_rect_packer_top.
// Mirrors the packer state to predict each result and compares every result transfer
// in order, under random idling on both channels. Depends on srp_pkg and the packer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          COORD_BITS   = 16;
    localparam logic [31:0] COORD_MAX    = (32'd1 << COORD_BITS) - 32'd1;
    localparam int          REPORT_LIMIT = 10;

    // One request as it crosses the input channel
    typedef struct {
        logic [srp_pkg::OP_BITS-1:0]    op;
        logic [srp_pkg::DIM_BITS-1:0]   rect_w;
        logic [srp_pkg::DIM_BITS-1:0]   rect_h;
        logic [srp_pkg::SPACE_BITS-1:0] new_hs;
        logic [srp_pkg::SPACE_BITS-1:0] new_vs;
        logic [srp_pkg::DIM_BITS-1:0]   new_lh;
    } t_request;

    typedef enum logic [1:0] {NO_ROOM, SAME_ROW, NEXT_ROW} t_fit;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [srp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [srp_pkg::CFG_DATA_BITS-1:0] i_cfg_data;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic [srp_pkg::OP_BITS-1:0]       i_operation;
    logic [srp_pkg::DIM_BITS-1:0]      i_rect_width;
    logic [srp_pkg::DIM_BITS-1:0]      i_rect_height;
    logic [srp_pkg::SPACE_BITS-1:0]    i_new_h_spacing;
    logic [srp_pkg::SPACE_BITS-1:0]    i_new_v_spacing;
    logic [srp_pkg::DIM_BITS-1:0]      i_new_line_height;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic                              o_fits;
    logic [srp_pkg::DIM_BITS-1:0]      o_pos_x;
    logic [srp_pkg::DIM_BITS-1:0]      o_pos_y;
    logic                              o_is_empty;

    // Mirror of the packer: registers, then working state
    logic [srp_pkg::DIM_BITS-1:0]   bnd_w, bnd_h, init_lh;
    logic [srp_pkg::SPACE_BITS-1:0] init_hs, init_vs;
    logic [srp_pkg::DIM_BITS-1:0]   cur_x, cur_y, n_placed, lh;
    logic [srp_pkg::SPACE_BITS-1:0] hs, vs;

    srp_pkg::t_result placements_due[$];
    int               mismatches   = 0;
    int               tx_gap_pct   = 0;
    int               rx_stall_pct = 0;

    shelf_rect_packer_top #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_rect_width      (i_rect_width),
        .i_rect_height     (i_rect_height),
        .i_new_h_spacing   (i_new_h_spacing),
        .i_new_v_spacing   (i_new_v_spacing),
        .i_new_line_height (i_new_line_height),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_fits            (o_fits),
        .o_pos_x           (o_pos_x),
        .o_pos_y           (o_pos_y),
        .o_is_empty        (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Generous bound on the whole run
    initial begin
        #(2_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [srp_pkg::DIM_BITS-1:0] rand_dim();
        return srp_pkg::DIM_BITS'($urandom);
    endfunction

    function automatic logic [srp_pkg::SPACE_BITS-1:0] rand_space();
        return srp_pkg::SPACE_BITS'($urandom);
    endfunction

    function automatic logic [srp_pkg::DIM_BITS-1:0] sat_coord(input logic [31:0] v);
        return (v > COORD_MAX) ? srp_pkg::DIM_BITS'(COORD_MAX) : srp_pkg::DIM_BITS'(v);
    endfunction

    function automatic void reset_mirror();
        bnd_w    = srp_pkg::RST_BOUND_WIDTH;
        bnd_h    = srp_pkg::RST_BOUND_HEIGHT;
        init_hs  = srp_pkg::RST_INIT_H_SPACE;
        init_vs  = srp_pkg::RST_INIT_V_SPACE;
        init_lh  = srp_pkg::RST_INIT_LINE_H;
        cur_x    = '0;
        cur_y    = '0;
        n_placed = '0;
        hs       = init_hs;
        vs       = init_vs;
        lh       = init_lh;
    endfunction

    // Register write: any listed register reloads spacings and line height
    function automatic void load_register(input logic [srp_pkg::CFG_IDX_BITS-1:0]  idx,
                                          input logic [srp_pkg::CFG_DATA_BITS-1:0] data);
        case (idx)
            srp_pkg::REG_BOUND_WIDTH:  bnd_w   = data;
            srp_pkg::REG_BOUND_HEIGHT: bnd_h   = data;
            srp_pkg::REG_INIT_H_SPACE: init_hs = data[srp_pkg::SPACE_BITS-1:0];
            srp_pkg::REG_INIT_V_SPACE: init_vs = data[srp_pkg::SPACE_BITS-1:0];
            srp_pkg::REG_INIT_LINE_H:  init_lh = data;
            default: return;
        endcase
        hs = init_hs;
        vs = init_vs;
        lh = init_lh;
    endfunction

    // Where a padded rectangle would go: this row, the next one, or nowhere
    function automatic t_fit shelf_fit(input logic [srp_pkg::DIM_BITS-1:0] w,
                                       input logic [srp_pkg::DIM_BITS-1:0] h);
        logic [31:0] tw, th, left;
        tw = 32'(hs) + 32'(hs) + 32'(w);
        th = 32'(vs) + 32'(vs) + 32'(h);
        if (tw > 32'(bnd_w) || h > lh)
            return NO_ROOM;
        // a cursor past a narrowed bound leaves no room in the row
        left = (cur_x > bnd_w) ? 32'd0 : 32'(bnd_w) - 32'(cur_x);
        if (left >= tw)
            return SAME_ROW;
        if (32'(cur_y) + 32'(vs) + 32'(lh) + th > 32'(bnd_h))
            return NO_ROOM;
        return NEXT_ROW;
    endfunction

    // Result of one request, advancing the mirrored state
    function automatic srp_pkg::t_result next_placement(input t_request rq);
        srp_pkg::t_result res;
        t_fit             fit;
        logic [31:0]      shifted, lowered;
        res.fits  = 1'b1;
        res.pos_x = '0;
        res.pos_y = '0;
        case (rq.op)
            srp_pkg::OP_ADD: begin
                fit = shelf_fit(rq.rect_w, rq.rect_h);
                if (fit == NO_ROOM) begin
                    res.fits = 1'b0;
                end else begin
                    if (fit == NEXT_ROW) begin
                        cur_y = sat_coord(32'(cur_y) + 32'(vs) + 32'(lh));
                        cur_x = '0;
                    end
                    res.pos_x = sat_coord(32'(cur_x) + 32'(hs));
                    res.pos_y = sat_coord(32'(cur_y) + 32'(vs));
                    cur_x     = sat_coord(32'(cur_x) + 32'(hs) + 32'(rq.rect_w));
                    // count sticks at its maximum
                    if (n_placed != srp_pkg::COUNT_MAX)
                        n_placed = n_placed + 1'b1;
                end
            end
            srp_pkg::OP_CHECK: res.fits = (shelf_fit(rq.rect_w, rq.rect_h) != NO_ROOM);
            srp_pkg::OP_CLEAR: begin
                cur_x    = '0;
                cur_y    = '0;
                n_placed = '0;
            end
            srp_pkg::OP_SET_HORIZ: begin
                // narrower padding pushes the cursor right, no further than the bound
                if (rq.new_hs < hs) begin
                    shifted = 32'(cur_x) + 32'(hs) - 32'(rq.new_hs);
                    cur_x   = sat_coord((shifted < 32'(bnd_w)) ? shifted : 32'(bnd_w));
                end
                hs = rq.new_hs;
            end
            srp_pkg::OP_SET_VERT: begin
                lowered = 32'(cur_y) + ((rq.new_vs > vs) ? 32'(rq.new_vs) : 32'(vs));
                cur_y   = sat_coord((lowered < 32'(bnd_h)) ? lowered : 32'(bnd_h));
                cur_x   = '0;
                vs      = rq.new_vs;
                lh      = rq.new_lh;
            end
            default: ;  // unused codes leave the state alone
        endcase
        res.is_empty = (n_placed == '0);
        return res;
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch %0d at %0t: %s", mismatches, $realtime, msg);
    endfunction

    // Compare one result transfer with the oldest prediction
    task automatic compare_placement();
        srp_pkg::t_result got, want;
        got.fits     = o_fits;
        got.pos_x    = o_pos_x;
        got.pos_y    = o_pos_y;
        got.is_empty = o_is_empty;
        if (placements_due.size() == 0) begin
            flag_mismatch($sformatf("result with none pending: fits %0b x %0d y %0d empty %0b",
                                    got.fits, got.pos_x, got.pos_y, got.is_empty));
        end else begin
            want = placements_due.pop_front();
            if (got.fits !== want.fits)
                flag_mismatch($sformatf("fits expected %0b got %0b", want.fits, got.fits));
            if (got.pos_x !== want.pos_x)
                flag_mismatch($sformatf("pos_x expected %0d got %0d", want.pos_x, got.pos_x));
            if (got.pos_y !== want.pos_y)
                flag_mismatch($sformatf("pos_y expected %0d got %0d", want.pos_y, got.pos_y));
            if (got.is_empty !== want.is_empty)
                flag_mismatch($sformatf("is_empty expected %0b got %0b",
                                        want.is_empty, got.is_empty));
        end
    endtask

    // Take results and stall the result channel at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            compare_placement();
        i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Present one request and hold it until the transfer
    task automatic send_request(input t_request rq);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_operation       <= rq.op;
        i_rect_width      <= rq.rect_w;
        i_rect_height     <= rq.rect_h;
        i_new_h_spacing   <= rq.new_hs;
        i_new_v_spacing   <= rq.new_vs;
        i_new_line_height <= rq.new_lh;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        placements_due.push_back(next_placement(rq));
    endtask

    // Directed request; fields the operation ignores get random values
    task automatic send_item(input logic [srp_pkg::OP_BITS-1:0]    op,
                             input logic [srp_pkg::DIM_BITS-1:0]   w,
                             input logic [srp_pkg::DIM_BITS-1:0]   h,
                             input logic [srp_pkg::SPACE_BITS-1:0] nhs,
                             input logic [srp_pkg::SPACE_BITS-1:0] nvs,
                             input logic [srp_pkg::DIM_BITS-1:0]   nlh);
        t_request rq;
        rq = '{op, w, h, nhs, nvs, nlh};
        if (op != srp_pkg::OP_ADD && op != srp_pkg::OP_CHECK) begin
            rq.rect_w = rand_dim();
            rq.rect_h = rand_dim();
        end
        if (op != srp_pkg::OP_SET_HORIZ)
            rq.new_hs = rand_space();
        if (op != srp_pkg::OP_SET_VERT) begin
            rq.new_vs = rand_space();
            rq.new_lh = rand_dim();
        end
        send_request(rq);
    endtask

    // Drop valid and hold until every predicted result has been taken
    task automatic settle();
        i_in_valid <= 1'b0;
        while (placements_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [srp_pkg::CFG_IDX_BITS-1:0]  idx,
                             input logic [srp_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        load_register(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_config(input logic [srp_pkg::CFG_DATA_BITS-1:0] bw,
                                input logic [srp_pkg::CFG_DATA_BITS-1:0] bh,
                                input logic [srp_pkg::CFG_DATA_BITS-1:0] h_pad,
                                input logic [srp_pkg::CFG_DATA_BITS-1:0] v_pad,
                                input logic [srp_pkg::CFG_DATA_BITS-1:0] row_h);
        settle();
        write_reg(srp_pkg::REG_BOUND_WIDTH, bw);
        write_reg(srp_pkg::REG_BOUND_HEIGHT, bh);
        write_reg(srp_pkg::REG_INIT_H_SPACE, h_pad);
        write_reg(srp_pkg::REG_INIT_V_SPACE, v_pad);
        write_reg(srp_pkg::REG_INIT_LINE_H, row_h);
    endtask

    // Mostly well-formed placements with random content, some noise
    function automatic t_request random_request();
        t_request rq;
        int       pick;
        rq   = '{srp_pkg::OP_ADD, rand_dim(), rand_dim(), rand_space(), rand_space(),
                 rand_dim()};
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
            rq.rect_w = srp_pkg::DIM_BITS'($urandom_range(0, 40));
            rq.rect_h = srp_pkg::DIM_BITS'($urandom_range(0, (lh > 64) ? 64 : lh));
        end else if (pick < 70) begin
            rq.op     = srp_pkg::OP_CHECK;
            rq.rect_w = srp_pkg::DIM_BITS'($urandom_range(0, 80));
            rq.rect_h = srp_pkg::DIM_BITS'($urandom_range(0, 80));
        end else if (pick < 73) begin
            rq.op = srp_pkg::OP_CLEAR;
        end else if (pick < 79) begin
            rq.op = srp_pkg::OP_SET_HORIZ;
            if ($urandom_range(0, 3) != 0)
                rq.new_hs = srp_pkg::SPACE_BITS'($urandom_range(0, 6));
        end else if (pick < 84) begin
            rq.op = srp_pkg::OP_SET_VERT;
            if ($urandom_range(0, 3) != 0) begin
                rq.new_vs = srp_pkg::SPACE_BITS'($urandom_range(0, 6));
                rq.new_lh = srp_pkg::DIM_BITS'($urandom_range(4, 64));
            end
        end else if (pick < 87) begin
            rq.op = srp_pkg::OP_BITS'(srp_pkg::OP_SET_VERT + $urandom_range(1, 3));
        end else if (pick < 93) begin
            // sizes up to the edges of the area
            rq.rect_w = srp_pkg::DIM_BITS'($urandom_range(0, bnd_w));
            rq.rect_h = srp_pkg::DIM_BITS'($urandom_range(0, lh));
        end
        return rq;
    endfunction

    // Every operation, field extremes, clamping of both cursors, unused codes
    task automatic test_directed_ops();
        send_item(srp_pkg::OP_ADD, 0, 0, 0, 0, 0);
        send_item(srp_pkg::OP_ADD, 10, 32, 0, 0, 0);
        send_item(srp_pkg::OP_ADD, 10, 33, 0, 0, 0);
        send_item(srp_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 0, 0, 0);
        send_item(srp_pkg::OP_CHECK, 1022, 0, 0, 0, 0);
        send_item(srp_pkg::OP_CHECK, 1023, 5, 0, 0, 0);
        send_item(srp_pkg::OP_ADD, 1000, 5, 0, 0, 0);
        send_item(srp_pkg::OP_SET_HORIZ, 0, 0, 0, 0, 0);
        send_item(srp_pkg::OP_SET_HORIZ, 0, 0, 12'hFFF, 0, 0);
        send_item(srp_pkg::OP_ADD, 10, 10, 0, 0, 0);
        send_item(srp_pkg::OP_SET_HORIZ, 0, 0, 0, 0, 0);
        send_item(srp_pkg::OP_ADD, 0, 0, 0, 0, 0);
        send_item(srp_pkg::OP_SET_VERT, 0, 0, 0, 12'hFFF, 16'hFFFF);
        send_item(srp_pkg::OP_ADD, 1, 1, 0, 0, 0);
        send_item(srp_pkg::OP_SET_VERT, 0, 0, 0, 0, 0);
        send_item(srp_pkg::OP_ADD, 5, 0, 0, 0, 0);
        send_item(srp_pkg::OP_ADD, 5, 1, 0, 0, 0);
        for (int k = 1; k <= 3; k++)
            send_item(srp_pkg::OP_BITS'(srp_pkg::OP_SET_VERT + k), 0, 0, 0, 0, 0);
        send_item(srp_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        send_item(srp_pkg::OP_CHECK, 1, 1, 0, 0, 0);
        send_item(srp_pkg::OP_SET_VERT, 0, 0, 0, 1, 32);
        send_item(srp_pkg::OP_ADD, 3, 3, 0, 0, 0);
    endtask

    // Register writes: extremes, masking, unlisted indexes, narrowed bound
    task automatic test_register_writes();
        settle();
        write_reg(srp_pkg::REG_BOUND_WIDTH, '0);
        send_item(srp_pkg::OP_ADD, 0, 0, 0, 0, 0);
        send_item(srp_pkg::OP_CHECK, 0, 0, 0, 0, 0);

        // spacing registers keep their low bits only
        write_config(16'hFFFF, 16'hFFFF, 16'hF000, 16'hFFFF, 16'hFFFF);
        send_item(srp_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        send_item(srp_pkg::OP_ADD, 16'hFFFF, 0, 0, 0, 0);
        send_item(srp_pkg::OP_ADD, 1, 1, 0, 0, 0);
        send_item(srp_pkg::OP_CHECK, 0, 0, 0, 0, 0);

        // writes past the register list must not reload the spacings
        send_item(srp_pkg::OP_SET_HORIZ, 0, 0, 7, 0, 0);
        settle();
        for (int k = 1; k <= 3; k++)
            write_reg(srp_pkg::CFG_IDX_BITS'(srp_pkg::REG_INIT_LINE_H + k),
                      srp_pkg::CFG_DATA_BITS'($urandom));
        send_item(srp_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        send_item(srp_pkg::OP_ADD, 1, 1, 0, 0, 0);

        // cursor left beyond a bound that shrank under it
        write_config(1024, 1024, 1, 1, 32);
        send_item(srp_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        send_item(srp_pkg::OP_ADD, 300, 4, 0, 0, 0);
        settle();
        write_reg(srp_pkg::REG_BOUND_WIDTH, 100);
        send_item(srp_pkg::OP_ADD, 10, 4, 0, 0, 0);
        send_item(srp_pkg::OP_CHECK, 98, 0, 0, 0, 0);
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input logic [srp_pkg::CFG_DATA_BITS-1:0] bw,
                                       input logic [srp_pkg::CFG_DATA_BITS-1:0] bh,
                                       input logic [srp_pkg::CFG_DATA_BITS-1:0] h_pad,
                                       input logic [srp_pkg::CFG_DATA_BITS-1:0] v_pad,
                                       input logic [srp_pkg::CFG_DATA_BITS-1:0] row_h,
                                       input int count);
        write_config(bw, bh, h_pad, v_pad, row_h);
        tx_gap_pct   = gap_pct;
        rx_stall_pct = stall_pct;
        send_item(srp_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        for (int n = 0; n < count; n++) begin
            // now and then hold off until the packer has delivered everything
            if ($urandom_range(0, 199) == 0)
                settle();
            send_request(random_request());
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= '0;
        i_cfg_data        <= '0;
        i_in_valid        <= 1'b0;
        i_operation       <= srp_pkg::OP_ADD;
        i_rect_width      <= '0;
        i_rect_height     <= '0;
        i_new_h_spacing   <= '0;
        i_new_v_spacing   <= '0;
        i_new_line_height <= '0;
        reset_mirror();
        tx_gap_pct   = 10;
        rx_stall_pct = 61;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_register_writes();
        test_random_traffic(10, 61, 1024, 1024, 1, 1, 32, 560);
        test_random_traffic(61, 10, 16'hFFFF, 16'hFFFF, 0, 0, 16, 560);
        test_random_traffic(0, 0, 200, 300, 3, 2, 24, 560);

        // drain, then allow for the output stage
        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && placements_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
